/* src/mldm_pkg.sv */
// ----------------------------------------------------------------------------
// mldm_pkg
// Shared types for the mode/length stream demultiplexer.
// ----------------------------------------------------------------------------
package mldm_pkg;

	localparam int unsigned ByteW = 8;

	typedef enum logic [2:0] {
		PH_MODE = 3'b001,
		PH_LEN  = 3'b010,
		PH_DATA = 3'b100
	} phase_t;

	typedef struct packed {
		logic             last;
		logic             empty_frame;
		logic [ByteW-1:0] frame_length;
		logic [ByteW-1:0] payload_byte;
		logic [ByteW-1:0] endpoint;
	} res_t;

	typedef struct packed {
		logic valid;
		res_t res;
	} res_slot_t;

endpackage

/* src/mldm_in_reg.sv */
// ----------------------------------------------------------------------------
// mldm_in_reg
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module mldm_in_reg
	import mldm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [ByteW-1:0] s_tdata,   // rx_byte
	input  logic             advance,
	output logic             valid_s1,
	output logic [ByteW-1:0] byte_s1
);

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

/* src/mldm_parser.sv */
// ----------------------------------------------------------------------------
// mldm_parser
// Frame header parser and endpoint filter; holds the mask register.
// ----------------------------------------------------------------------------
module mldm_parser
	import mldm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [ByteW-1:0] cfg_data,
	input  logic             advance,
	input  logic             valid_s1,
	input  logic [ByteW-1:0] byte_s1,
	output res_slot_t        slot
);

	phase_t           phase_q, phase_d;
	logic [ByteW-1:0] mask_q;
	logic [ByteW-1:0] ep_q, ep_d;
	logic [ByteW-1:0] rem_q, rem_d;
	logic [ByteW-1:0] len_q, len_d;
	logic             acc;

	assign cfg_ready = 1'b1;
	assign acc       = ((ep_q & mask_q) == ep_q);

	always_comb begin
		phase_d                = phase_q;
		ep_d                   = ep_q;
		rem_d                  = rem_q;
		len_d                  = len_q;
		slot.valid             = 1'b0;
		slot.res.endpoint      = ep_q;
		slot.res.payload_byte  = byte_s1;
		slot.res.frame_length  = len_q;
		slot.res.empty_frame   = 1'b0;
		slot.res.last          = 1'b0;
		unique case (phase_q)
			PH_LEN: begin
				len_d                 = byte_s1;
				rem_d                 = byte_s1;
				slot.res.frame_length = byte_s1;
				if (byte_s1 == '0) begin
					phase_d               = PH_MODE;
					slot.valid            = valid_s1 && acc;
					slot.res.payload_byte = '0;
					slot.res.empty_frame  = 1'b1;
					slot.res.last         = 1'b1;
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				rem_d         = rem_q - ByteW'(1);
				slot.res.last = (rem_d == '0);
				slot.valid    = valid_s1 && acc;
				if (rem_d == '0) begin
					phase_d = PH_MODE;
				end
			end
			default: begin
				ep_d    = byte_s1;
				phase_d = PH_LEN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MODE;
			ep_q    <= '0;
			rem_q   <= '0;
			len_q   <= '0;
			mask_q  <= '1;
		end else begin
			if (advance) begin
				phase_q <= phase_d;
				ep_q    <= ep_d;
				rem_q   <= rem_d;
				len_q   <= len_d;
			end
			if (cfg_valid && cfg_ready) begin
				mask_q <= cfg_data;
			end
		end
	end

endmodule

/* src/mldm_out_reg.sv */
// ----------------------------------------------------------------------------
// mldm_out_reg
// Result register on the master side.
// ----------------------------------------------------------------------------
module mldm_out_reg
	import mldm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  res_slot_t           slot,
	output logic                advance,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [3*ByteW-1:0]  m_tdata,   // endpoint, payload_byte, frame_length
	output logic                m_tlast,   // last
	output logic                m_tuser    // empty_frame
);

	res_t res_s2;

	assign advance = valid_s1 && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= slot.valid;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && slot.valid) begin
			res_s2 <= slot.res;
		end
	end

	assign m_tdata = {res_s2.frame_length, res_s2.payload_byte, res_s2.endpoint};
	assign m_tlast = res_s2.last;
	assign m_tuser = res_s2.empty_frame;

endmodule

/* src/mode_length_stream_demultiplexer.sv */
// ----------------------------------------------------------------------------
// mode_length_stream_demultiplexer
// Parses mode/length/payload frames and delivers payload and empty-frame marks of enabled modes.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle while the result side does not stall.
// Each byte passes the input register, is parsed combinationally and lands in
// the result register; the rate is set only by the result
// handshake, as the parser state advances once per byte. Header bytes of a
// non-empty frame and payload of masked-out modes give no transaction. The
// mask register resets to all ones and should be written only while idle.
module mode_length_stream_demultiplexer
	import mldm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [ByteW-1:0]    s_tdata,   // rx_byte
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [3*ByteW-1:0]  m_tdata,   // endpoint, payload_byte, frame_length
	output logic                m_tlast,   // last
	output logic                m_tuser,   // empty_frame
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [ByteW-1:0]    cfg_data   // endpoint_mask
);

	logic             advance;
	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	res_slot_t        slot;

	mldm_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	mldm_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.slot      (slot)
	);

	mldm_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.slot     (slot),
		.advance  (advance),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

/* test/tb_mode_length_stream_demultiplexer.sv */
// ----------------------------------------------------------------------------
// tb_mode_length_stream_demultiplexer
// Self-checking bench for the mode/length frame demultiplexer.
// ----------------------------------------------------------------------------
// A short table of frames is sent first, with a few results typed in by hand.
// Random well-formed frames follow under several mask settings and idling
// patterns. All other results are checked against a local frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mode_length_stream_demultiplexer;
	import mldm_pkg::*;

	localparam int unsigned WatchdogLimit = 2000;
	localparam int unsigned HoldCycles    = 300;
	localparam int unsigned SettleCycles  = 8;
	localparam int unsigned PhaseItems    = 200;

	typedef enum logic {ROW_BYTE, ROW_MASK} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic [ByteW-1:0] value;
		bit               pinned;
		res_t             res;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [ByteW-1:0]   s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [3*ByteW-1:0] m_tdata;
	logic               m_tlast;
	logic               m_tuser;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [ByteW-1:0]   cfg_data = '0;

	// parser copy
	phase_t           rx_phase = PH_MODE;
	logic [ByteW-1:0] rx_mask = 8'hFF;
	logic [ByteW-1:0] rx_endpoint = '0;
	logic [ByteW-1:0] rx_remaining = '0;
	logic [ByteW-1:0] rx_length = '0;

	res_t             due_results [$];
	logic [ByteW-1:0] frame_bytes [$];
	bit               item_pinned = 1'b0;
	res_t             item_res = '0;
	int unsigned      mismatches = 0;
	int unsigned      src_idle_pct = 0;
	int unsigned      sink_stall_pct = 0;
	bit               hold_req = 1'b0;
	row_t             script [27];

	mode_length_stream_demultiplexer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic res_t res_of(input logic [7:0] ep, input logic [7:0] pl,
			input logic [7:0] len, input logic emp, input logic lst);
		res_t r;
		r.endpoint     = ep;
		r.payload_byte = pl;
		r.frame_length = len;
		r.empty_frame  = emp;
		r.last         = lst;
		return r;
	endfunction

	// Advances the parser by one byte; returns 1 when the byte yields a result.
	function bit parse_byte(input logic [ByteW-1:0] b, output res_t r);
		bit enabled;
		enabled = ((rx_endpoint & rx_mask) == rx_endpoint);
		r = '0;
		case (rx_phase)
			PH_LEN: begin
				rx_length    = b;
				rx_remaining = b;
				if (b == 0) begin
					rx_phase = PH_MODE;
					r = res_of(rx_endpoint, 8'h00, 8'h00, 1'b1, 1'b1);
					return enabled;
				end
				rx_phase = PH_DATA;
				return 1'b0;
			end
			PH_DATA: begin
				rx_remaining = rx_remaining - 8'd1;
				if (rx_remaining == 0)
					rx_phase = PH_MODE;
				r = res_of(rx_endpoint, b, rx_length, 1'b0, rx_remaining == 0);
				return enabled;
			end
			default: begin
				rx_endpoint = b;
				rx_phase    = PH_LEN;
				return 1'b0;
			end
		endcase
	endfunction

	always @(posedge clk) begin
		res_t r;
		res_t want;
		bit   got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				rx_mask = cfg_data;
			if (s_tvalid && s_tready) begin
				got = parse_byte(s_tdata, r);
				if (item_pinned)
					due_results.push_back(item_res);
				else if (got)
					due_results.push_back(r);
			end
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected transaction, tdata %h tlast %b tuser %b",
						$time, m_tdata, m_tlast, m_tuser);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					if (m_tdata[7:0] !== want.endpoint) begin
						$display("%0t: endpoint expected %h actual %h",
							$time, want.endpoint, m_tdata[7:0]);
						mismatches++;
					end
					if (m_tdata[15:8] !== want.payload_byte) begin
						$display("%0t: payload_byte expected %h actual %h",
							$time, want.payload_byte, m_tdata[15:8]);
						mismatches++;
					end
					if (m_tdata[23:16] !== want.frame_length) begin
						$display("%0t: frame_length expected %h actual %h",
							$time, want.frame_length, m_tdata[23:16]);
						mismatches++;
					end
					if (m_tuser !== want.empty_frame) begin
						$display("%0t: empty_frame expected %b actual %b",
							$time, want.empty_frame, m_tuser);
						mismatches++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t: last expected %b actual %b",
							$time, want.last, m_tlast);
						mismatches++;
					end
				end
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HoldCycles - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
			end
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WatchdogLimit) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("mode_length_stream_demultiplexer test failed");
		$finish;
	end

	task automatic put_byte(input logic [ByteW-1:0] b, input bit pin, input res_t r);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid    <= 1'b1;
		s_tdata     <= b;
		item_pinned <= pin;
		item_res    <= r;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// drop valid, let all results drain and the pipeline empty
	task automatic settle();
		@(negedge clk);
		s_tvalid    <= 1'b0;
		item_pinned <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_mask(input logic [ByteW-1:0] m);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly short frames, a few long ones, modes biased towards the mask
	task automatic make_frame();
		int unsigned      pick;
		int unsigned      len;
		logic [ByteW-1:0] mode;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			mode = 8'h00;
		else if (pick < 60)
			mode = ByteW'($urandom) & rx_mask;
		else
			mode = ByteW'($urandom);
		pick = $urandom_range(0, 199);
		if (pick < 2)
			len = 255;
		else if (pick < 10)
			len = $urandom_range(9, 40);
		else
			len = $urandom_range(0, 8);
		frame_bytes.push_back(mode);
		frame_bytes.push_back(ByteW'(len));
		repeat (len) frame_bytes.push_back(ByteW'($urandom));
	endtask

	initial begin
		logic [ByteW-1:0] masks [4];
		int unsigned      idle_of [4];
		int unsigned      stall_of [4];
		int unsigned      budget;

		script = '{
			'{ROW_BYTE, 8'h00, 1'b0, '0},
			'{ROW_BYTE, 8'h00, 1'b1, res_of(8'h00, 8'h00, 8'h00, 1'b1, 1'b1)},
			'{ROW_BYTE, 8'hFF, 1'b0, '0},
			'{ROW_BYTE, 8'h01, 1'b0, '0},
			'{ROW_BYTE, 8'hFF, 1'b1, res_of(8'hFF, 8'hFF, 8'h01, 1'b0, 1'b1)},
			'{ROW_BYTE, 8'hA5, 1'b0, '0},
			'{ROW_BYTE, 8'h03, 1'b0, '0},
			'{ROW_BYTE, 8'h00, 1'b0, '0},
			'{ROW_BYTE, 8'h80, 1'b0, '0},
			'{ROW_BYTE, 8'h7F, 1'b0, '0},
			'{ROW_MASK, 8'h0F, 1'b0, '0},
			// masked-out mode: payload and empty frame both dropped
			'{ROW_BYTE, 8'h10, 1'b0, '0},
			'{ROW_BYTE, 8'h02, 1'b0, '0},
			'{ROW_BYTE, 8'hAA, 1'b0, '0},
			'{ROW_BYTE, 8'h55, 1'b0, '0},
			'{ROW_BYTE, 8'h10, 1'b0, '0},
			'{ROW_BYTE, 8'h00, 1'b0, '0},
			'{ROW_BYTE, 8'h05, 1'b0, '0},
			'{ROW_BYTE, 8'h01, 1'b0, '0},
			'{ROW_BYTE, 8'hC3, 1'b1, res_of(8'h05, 8'hC3, 8'h01, 1'b0, 1'b1)},
			// mask opened halfway through a frame
			'{ROW_BYTE, 8'h30, 1'b0, '0},
			'{ROW_BYTE, 8'h04, 1'b0, '0},
			'{ROW_BYTE, 8'h11, 1'b0, '0},
			'{ROW_BYTE, 8'h22, 1'b0, '0},
			'{ROW_MASK, 8'hFF, 1'b0, '0},
			'{ROW_BYTE, 8'h33, 1'b0, '0},
			'{ROW_BYTE, 8'h44, 1'b0, '0}
		};
		masks    = '{8'hFF, ByteW'($urandom), 8'h00, ByteW'($urandom)};
		idle_of  = '{0, 49, 0, 13};
		stall_of = '{0, 0, 49, 13};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (script[i]) begin
			if (script[i].kind == ROW_MASK) begin
				settle();
				write_mask(script[i].value);
			end else begin
				put_byte(script[i].value, script[i].pinned, script[i].res);
			end
		end

		for (int p = 0; p < 4; p++) begin
			settle();
			write_mask(masks[p]);
			src_idle_pct   = idle_of[p];
			sink_stall_pct = stall_of[p];
			if (p == 0)
				hold_req = 1'b1;
			budget = PhaseItems;
			while (budget > 0) begin
				if (frame_bytes.size() == 0)
					make_frame();
				put_byte(frame_bytes.pop_front(), 1'b0, '0);
				budget--;
			end
		end
		settle();

		if (mismatches == 0)
			$display("mode_length_stream_demultiplexer test passed");
		else
			$display("mode_length_stream_demultiplexer test failed");
		$finish;
	end

endmodule
